// File: hdl/bfim_pkg.sv
// Shared constants, types and helpers of the Bloom filter membership block.
package bfim_pkg;

    localparam int unsigned BIT_CAPACITY = 65536;
    localparam int unsigned HASH_COUNT   = 3;
    localparam int unsigned IDX_W        = $clog2(BIT_CAPACITY);
    localparam int unsigned CNT_W        = IDX_W + 1;
    localparam int unsigned HSEL_W       = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

    localparam logic [31:0] XP2 = 32'h85EBCA77;
    localparam logic [31:0] XP3 = 32'hC2B2AE3D;
    localparam logic [31:0] XP4 = 32'h27D4EB2F;
    localparam logic [31:0] XP5 = 32'h165667B1;

    localparam logic [CNT_W-1:0] BIT_COUNT_RESET = CNT_W'(BIT_CAPACITY);
    localparam logic [31:0] SEED_FIRST_RESET  = 32'h9747B28C;
    localparam logic [31:0] SEED_SECOND_RESET = 32'h5D3A11E7;
    localparam logic [31:0] SEED_THIRD_RESET  = 32'h1F8C3E96;

    localparam logic [1:0] REG_BIT_COUNT   = 2'd0;
    localparam logic [1:0] REG_SEED_FIRST  = 2'd1;
    localparam logic [1:0] REG_SEED_SECOND = 2'd2;
    localparam logic [1:0] REG_SEED_THIRD  = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_key;
        logic              hash_start;
        logic [HSEL_W-1:0] hash_sel;
        logic              div_start;
        logic              mem_write;
        logic              mem_read;
        logic              clear_write;
        logic [IDX_W-1:0]  clear_addr;
    } bfim_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hash_done;
        logic div_done;
    } bfim_status_t;

endpackage

// File: hdl/bloom_filter_int32_membership_core.sv
// Top level of the Bloom filter membership block: configuration registers and wiring.
//
// After reset the block sweeps its 65536-entry bit memory clear, one entry per cycle, and
// accepts no item until the sweep is done. Each item then computes three seeded XXH32 hashes
// of the key, one after another on a single shared 32x32 multiplier, and reduces each
// modulo the bit count with a one-bit-per-cycle divider; the block takes no new item until
// the last one is done. An insert sets three bits and gives no result; a query gives one
// result item carrying present. A bit count of zero acts as one, and a bit count above
// the capacity acts as the capacity.
module bloom_filter_int32_membership_core
    import bfim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic signed [31:0]  key,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                present
);

    logic [CNT_W-1:0] bit_count_reg;
    logic [31:0]      seed_first_reg, seed_second_reg, seed_third_reg;
    logic [CNT_W-1:0] modulus;
    bfim_cmd_t        cmd;
    bfim_status_t     status;
    logic             rd_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bit_count_reg   <= BIT_COUNT_RESET;
            seed_first_reg  <= SEED_FIRST_RESET;
            seed_second_reg <= SEED_SECOND_RESET;
            seed_third_reg  <= SEED_THIRD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_BIT_COUNT:   bit_count_reg   <= cfg_data[CNT_W-1:0];
                REG_SEED_FIRST:  seed_first_reg  <= cfg_data;
                REG_SEED_SECOND: seed_second_reg <= cfg_data;
                REG_SEED_THIRD:  seed_third_reg  <= cfg_data;
                default:         bit_count_reg   <= bit_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (bit_count_reg == '0) begin
            modulus = CNT_W'(1);
        end else if (bit_count_reg > CNT_W'(BIT_CAPACITY)) begin
            modulus = CNT_W'(BIT_CAPACITY);
        end else begin
            modulus = bit_count_reg;
        end
    end

    bfim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .present   (present),
        .cmd       (cmd),
        .status    (status),
        .rd_bit    (rd_bit)
    );

    bfim_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .key         (key),
        .modulus     (modulus),
        .seed_first  (seed_first_reg),
        .seed_second (seed_second_reg),
        .seed_third  (seed_third_reg),
        .rd_bit      (rd_bit)
    );

endmodule

// File: hdl/bfim_datapath.sv
// Datapath: XXH32 on a shared multiplier, restoring divider and the filter bit memory.
module bfim_datapath
    import bfim_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bfim_cmd_t          cmd,
    output bfim_status_t       status,
    input  logic [31:0]        key,
    input  logic [CNT_W-1:0]   modulus,
    input  logic [31:0]        seed_first,
    input  logic [31:0]        seed_second,
    input  logic [31:0]        seed_third,
    output logic               rd_bit
);

    typedef enum logic [2:0] {
        H_IDLE, H_M1, H_M2, H_M3, H_M4, H_DONE
    } hstep_t;

    hstep_t      hstep_reg, hstep_next;
    logic [31:0] key_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] prod_reg;
    logic        prod_phase_reg;
    logic [31:0] seed_sel;
    logic [31:0] mul_a, mul_b, prod;

    logic [31:0]      rem_reg, quo_reg;
    logic [5:0]       div_cnt_reg;
    logic             div_busy_reg;
    logic [32:0]      trial;
    logic [CNT_W-1:0] m_reg;

    logic mem [BIT_CAPACITY];

    always_comb
    begin
        case (cmd.hash_sel)
            2'd0:    seed_sel = seed_first;
            2'd1:    seed_sel = seed_second;
            default: seed_sel = seed_third;
        endcase
    end

    // One multiply per step; the product is registered before the next use.
    always_comb
    begin
        mul_a = h_reg;
        mul_b = XP3;
        case (hstep_reg)
            H_M1:    begin mul_a = {h_reg[14:0], h_reg[31:15]}; mul_b = XP4; end
            H_M2:    begin mul_a = h_reg ^ (h_reg >> 15); mul_b = XP2; end
            H_M3:    begin mul_a = h_reg ^ (h_reg >> 13); mul_b = XP3; end
            default: begin mul_a = key_reg; mul_b = XP3; end
        endcase
        prod = 32'(mul_a * mul_b);
    end

    always_comb
    begin
        hstep_next = hstep_reg;
        h_next     = h_reg;
        if (cmd.hash_start) begin
            hstep_next = H_M4;
            h_next     = seed_sel + XP5 + 32'd4;
        end else if (prod_phase_reg) begin
            case (hstep_reg)
                H_M4:    begin h_next = h_reg + prod_reg; hstep_next = H_M1; end
                H_M1:    begin h_next = prod_reg; hstep_next = H_M2; end
                H_M2:    begin h_next = prod_reg; hstep_next = H_M3; end
                H_M3:    begin h_next = prod_reg ^ (prod_reg >> 16); hstep_next = H_DONE; end
                default: hstep_next = hstep_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hstep_reg      <= H_IDLE;
            prod_phase_reg <= 1'b0;
        end else begin
            hstep_reg <= hstep_next;
            if (cmd.hash_start) begin
                prod_phase_reg <= 1'b0;
            end else if (hstep_reg != H_IDLE && hstep_reg != H_DONE) begin
                prod_phase_reg <= ~prod_phase_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key) begin
            key_reg <= key;
        end
        h_reg    <= h_next;
        prod_reg <= prod;
    end

    // Restoring divider, one quotient bit per cycle; only the remainder is kept.
    assign trial = {rem_reg, quo_reg[31]} - {16'd0, m_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= 6'd32;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg - 6'd1;
            if (div_cnt_reg == 6'd1) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= h_reg;
            m_reg   <= modulus;
        end else if (div_busy_reg) begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
            end else begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
            end
        end
    end

    assign status.hash_done = (hstep_reg == H_DONE) && !cmd.hash_start;
    assign status.div_done  = !div_busy_reg && !cmd.div_start;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_write) begin
            mem[cmd.clear_addr] <= 1'b0;
        end else if (cmd.mem_write) begin
            mem[rem_reg[IDX_W-1:0]] <= 1'b1;
        end
        if (cmd.mem_read) begin
            rd_bit <= mem[rem_reg[IDX_W-1:0]];
        end
    end

endmodule

// File: hdl/bfim_ctrl.sv
// Controller state machine: clearing pass, hash and reduction sequencing, result handshake.
module bfim_ctrl
    import bfim_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         operation,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         present,
    output bfim_cmd_t    cmd,
    input  bfim_status_t status,
    input  logic         rd_bit
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_DIV, S_MEM, S_CHECK, S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [HSEL_W-1:0] hsel_reg, hsel_next;
    logic              query_reg, query_next;
    logic              all_reg, all_next;
    logic              out_valid_next, present_next;
    logic              last_hash;

    assign last_hash = (hsel_reg == HSEL_W'(HASH_COUNT - 1));
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        hsel_next       = hsel_reg;
        query_next      = query_reg;
        all_next        = all_reg;
        out_valid_next  = out_valid;
        present_next    = present;
        cmd             = '0;
        cmd.hash_sel    = hsel_reg;
        cmd.clear_addr  = clr_reg;
        if (out_valid && !out_stall) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load_key = 1'b1;
                    query_next   = (operation == OP_QUERY);
                    all_next     = 1'b1;
                    hsel_next    = '0;
                    state_next   = S_HASH;
                end
            end
            S_HASH:
            begin
                // The hash unit is always idle here, so it is started at once.
                cmd.hash_start = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                if (status.hash_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_MEM;
                end
            end
            S_MEM:
            begin
                if (status.div_done) begin
                    if (query_reg) begin
                        cmd.mem_read = 1'b1;
                        state_next   = S_CHECK;
                    end else begin
                        cmd.mem_write = 1'b1;
                        if (last_hash) begin
                            state_next = S_IDLE;
                        end else begin
                            hsel_next  = hsel_reg + 1'b1;
                            state_next = S_HASH;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                all_next = all_reg & rd_bit;
                if (last_hash) begin
                    state_next = S_OUT;
                end else begin
                    hsel_next  = hsel_reg + 1'b1;
                    state_next = S_HASH;
                end
            end
            S_OUT:
            begin
                if (!out_valid || !out_stall) begin
                    out_valid_next = 1'b1;
                    present_next   = all_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hsel_reg  <= '0;
            query_reg <= 1'b0;
            all_reg   <= 1'b1;
            out_valid <= 1'b0;
            present   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hsel_reg  <= hsel_next;
            query_reg <= query_next;
            all_reg   <= all_next;
            out_valid <= out_valid_next;
            present   <= present_next;
        end
    end

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the Bloom filter membership core: directed table, then random items.
module testbench;
    import bfim_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_BIT_COUNT;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_INSERT;
    logic signed [31:0] key = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        present;

    bloom_filter_int32_membership_core dut (.*);

    always #6 clk = ~clk;

    // Own copy of the filter contents and registers.
    bit          shadow_bits [BIT_CAPACITY];
    logic [16:0] shadow_count;
    logic [31:0] shadow_seed [3];
    bit          answers_due [$];
    int          mismatches = 0;
    int          answers_seen = 0;
    bit          calm = 1'b0;

    // Per-row expectation in the directed table: 0 or 1 fixed, 2 from the predictor.
    typedef struct {
        logic        op;
        logic [31:0] k;
        int          fixed;
    } row_t;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] key_hash(input logic [31:0] w, input logic [31:0] s);
        logic [31:0] h;
        h = s + 32'h165667B1 + 32'd4;
        h = h + w * 32'hC2B2AE3D;
        h = rol32(h, 17) * 32'h27D4EB2F;
        h = h ^ (h >> 15);
        h = h * 32'h85EBCA77;
        h = h ^ (h >> 13);
        h = h * 32'hC2B2AE3D;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // Applies an item to the shadow filter; returns membership for a query.
    function automatic bit filter_apply(input logic op, input logic [31:0] k);
        logic [31:0] m;
        logic [31:0] idx;
        bit hit;
        m = shadow_count;
        if (m == 0) m = 1;
        if (m > BIT_CAPACITY) m = BIT_CAPACITY;
        hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            idx = key_hash(k, shadow_seed[i]) % m;
            if (op == OP_QUERY)
            begin
                if (!shadow_bits[idx]) hit = 1'b0;
            end
            else
                shadow_bits[idx] = 1'b1;
        end
        return hit;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_BIT_COUNT) shadow_count = v[16:0];
        else shadow_seed[idx - 1] = v;
    endtask

    // Drives one item from the falling edge and holds it until it is taken.
    task automatic send_item(input logic op, input logic [31:0] k, input int fixed);
        bit hit;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 22)
            @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = filter_apply(op, k);
        if (op == OP_QUERY)
        begin
            if (fixed != 2 && fixed != int'(hit))
                report_mismatch($sformatf("table expects %0d, predictor %0d", fixed, hit));
            answers_due.push_back(hit);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 22);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            answers_seen++;
            if (answers_due.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                bit want;
                want = answers_due.pop_front();
                if (present !== want)
                    report_mismatch($sformatf("present %b, expected %b", present, want));
            end
        end
    end

    initial
    begin
        row_t plan [$];
        logic [31:0] pool [$];
        logic [31:0] k;
        int phase;
        shadow_count = 17'd65536;
        shadow_seed[0] = SEED_FIRST_RESET;
        shadow_seed[1] = SEED_SECOND_RESET;
        shadow_seed[2] = SEED_THIRD_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // After reset the filter is empty, so the first queries must miss.
        plan.push_back('{OP_QUERY,  32'h0000_0000, 0});
        plan.push_back('{OP_QUERY,  32'h8000_0000, 0});
        plan.push_back('{OP_QUERY,  32'h7FFF_FFFF, 0});
        plan.push_back('{OP_INSERT, 32'h0000_0000, 2});
        plan.push_back('{OP_QUERY,  32'h0000_0000, 1});
        plan.push_back('{OP_INSERT, 32'h8000_0000, 2});
        plan.push_back('{OP_QUERY,  32'h8000_0000, 1});
        plan.push_back('{OP_INSERT, 32'hFFFF_FFFF, 2});
        plan.push_back('{OP_QUERY,  32'hFFFF_FFFF, 1});
        plan.push_back('{OP_QUERY,  32'h7FFF_FFFF, 2});
        plan.push_back('{OP_INSERT, 32'h0000_0001, 2});
        plan.push_back('{OP_QUERY,  32'h0000_0001, 1});
        plan.push_back('{OP_QUERY,  32'h1234_5678, 2});
        foreach (plan[i])
            send_item(plan[i].op, plan[i].k, plan[i].fixed);
        drain();

        // With one bit in use every index is zero, so all queries hit once it is set.
        write_reg(REG_BIT_COUNT, 32'd1);
        send_item(OP_QUERY, 32'hDEAD_BEEF, 2);
        send_item(OP_INSERT, 32'h0BAD_F00D, 2);
        send_item(OP_QUERY, 32'hCAFE_0001, 1);
        drain();
        // A bit count of zero acts as one.
        write_reg(REG_BIT_COUNT, 32'd0);
        send_item(OP_QUERY, 32'h5555_AAAA, 1);
        drain();
        // Above capacity saturates.
        write_reg(REG_BIT_COUNT, 32'h1FFFF);
        send_item(OP_QUERY, 32'h0000_0000, 1);
        send_item(OP_QUERY, 32'h4444_3333, 2);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin
                    write_reg(REG_BIT_COUNT, 32'd97);
                    write_reg(REG_SEED_FIRST, 32'h0000_0000);
                    write_reg(REG_SEED_SECOND, 32'hFFFF_FFFF);
                    write_reg(REG_SEED_THIRD, $urandom);
                end
                1: begin
                    write_reg(REG_BIT_COUNT, $urandom_range(2, 4000));
                    write_reg(REG_SEED_FIRST, $urandom);
                    write_reg(REG_SEED_SECOND, $urandom);
                    write_reg(REG_SEED_THIRD, 32'hFFFF_FFFF);
                end
                2: write_reg(REG_BIT_COUNT, 32'd65535);
                default: write_reg(REG_BIT_COUNT, 32'd65536);
            endcase
            calm = (phase == 2);
            pool.delete();
            for (int n = 0; n < 100; n++)
            begin
                // Queries mostly revisit inserted keys so that hits occur.
                if ($urandom_range(1) == 0 || pool.size() == 0)
                begin
                    k = $urandom;
                    pool.push_back(k);
                    send_item(OP_INSERT, k, 2);
                end
                else if ($urandom_range(2) != 0)
                    send_item(OP_QUERY, pool[$urandom_range(pool.size() - 1)], 2);
                else
                    send_item(OP_QUERY, $urandom, 2);
            end
            drain();
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
